### src/mbps_pkg.sv
// shared constants, types and helper functions of the masked byte pattern scanner
`default_nettype none

package mbps_pkg;

    // window depth and usable pattern length
    localparam int MAX_PATTERN = 16;
    localparam int CFG_BYTES   = 16;
    localparam int LIM         = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
    localparam int IDX_W       = $clog2(CFG_BYTES);
    localparam int LEN_W       = 5;

    // configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE    = 3'd4;

    localparam int ADDR_W = 32;

    typedef logic [7:0] t_byte;

    // per-cell control from the top level
    typedef struct packed {
        logic advance;
        logic clear;
        logic enable;
    } t_cell_ctl;

    // per-cell reference: the pattern byte and its nibble mask
    typedef struct packed {
        t_byte pattern;
        t_byte mask;
    } t_cell_ref;

    // pattern byte idx out of the two pattern words
    function automatic t_byte pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [IDX_W-1:0] idx);
        logic [63:0] word;
        word = idx[IDX_W-1] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

    // expand the nibble mask pair of byte idx to a byte mask
    function automatic t_byte mask_byte(input logic [31:0] mask, input logic [IDX_W-1:0] idx);
        logic [1:0] pair;
        pair = mask[{idx, 1'b0} +: 2];
        return {{4{pair[1]}}, {4{pair[0]}}};
    endfunction

endpackage

`default_nettype wire

### src/mbps_cell.sv
// one window cell: holds a byte and its valid flag, compares the incoming byte
`default_nettype none

module mbps_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mbps_pkg::t_cell_ctl   i_ctl,
    input  mbps_pkg::t_cell_ref   i_ref,
    input  mbps_pkg::t_byte       i_shift_byte,
    input  wire                   i_shift_valid,
    output mbps_pkg::t_byte       o_byte,
    output logic                  o_valid,
    output logic                  o_ok
);
    import mbps_pkg::*;

    t_byte r_byte;
    logic  r_valid;
    logic  n_valid;

    // value this cell takes on the current beat; a region start empties it
    assign n_valid = i_shift_valid & ~i_ctl.clear;

    // masked compare of the byte entering this cell
    assign o_ok = ~i_ctl.enable
                | (n_valid & (((i_shift_byte ^ i_ref.pattern) & i_ref.mask) == 8'h00));

    // byte storage, shifts toward the next cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_byte <= i_shift_byte;
        end
    end

    // fill flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= n_valid;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

### src/masked_byte_pattern_scanner_core.sv
// top level of the masked byte pattern scanner: cell chain, match logic, output skid
//
// While o_ready is high the scanner takes one byte per clock and returns a registered
// result beat per byte. The window is a chain of 16 cells, each holding one recent byte
// of the current region; all cells compare their byte to the matching pattern byte in
// the same cycle. An output register plus one skid register let one more input beat be
// taken while the consumer stalls. The user writes configuration through a plain write
// port while no beats are in flight; the block does not enforce this. Writing
// single_mode restarts a single-match search. No clearing pass is needed after reset.
`default_nettype none

module masked_byte_pattern_scanner_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [7:0]                        i_data_byte,
    input  wire [mbps_pkg::ADDR_W-1:0]       i_byte_address,
    input  wire                              i_region_start,
    // output channel
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_match_found,
    output logic [mbps_pkg::ADDR_W-1:0]      o_match_address,
    output logic                             o_search_done
);
    import mbps_pkg::*;

    // configuration registers
    logic [63:0]      r_pattern_lo;
    logic [63:0]      r_pattern_hi;
    logic [31:0]      r_nibble_mask;
    logic [LEN_W-1:0] r_length;
    logic             r_single;
    logic             r_found;

    logic             w_fire;
    logic [LEN_W-1:0] w_len;
    logic [LIM-1:0]   w_ok;
    t_byte            w_byte  [LIM];
    logic             w_valid [LIM];
    logic             w_hit;
    logic             w_done;
    logic [ADDR_W-1:0] w_addr;

    // output and skid stages
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_done;
    logic              r_skid_valid;
    logic              r_skid_found;
    logic [ADDR_W-1:0] r_skid_addr;
    logic              r_skid_done;

    assign o_ready = ~r_skid_valid;
    assign w_fire  = i_valid & o_ready;

    // length saturated to the window depth
    assign w_len = (r_length > LEN_W'(LIM)) ? LEN_W'(LIM) : r_length;

    // configuration write decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_lo  <= '0;
            r_pattern_hi  <= '0;
            r_nibble_mask <= '0;
            r_length      <= LEN_W'(1);
            r_single      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pattern_lo  <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_hi  <= i_cfg_data;
                CFG_NIBBLE_MASK:    r_nibble_mask <= i_cfg_data[31:0];
                CFG_PATTERN_LENGTH: r_length      <= i_cfg_data[LEN_W-1:0];
                CFG_SINGLE_MODE:    r_single      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // cell chain: cell k holds the byte k positions back, compares pattern byte len-1-k
    for (genvar k = 0; k < LIM; k++) begin : g_cell
        t_cell_ctl        w_ctl;
        t_cell_ref        w_ref;
        logic [IDX_W-1:0] w_idx;
        t_byte            w_in_byte;
        logic             w_in_valid;

        assign w_idx          = IDX_W'(w_len - LEN_W'(k) - LEN_W'(1));
        assign w_ctl.advance  = w_fire;
        assign w_ctl.clear    = (k != 0) ? i_region_start : 1'b0;
        assign w_ctl.enable   = LEN_W'(k) < w_len;
        assign w_ref.pattern  = pattern_byte(r_pattern_lo, r_pattern_hi, w_idx);
        assign w_ref.mask     = mask_byte(r_nibble_mask, w_idx);

        if (k == 0) begin : g_head
            assign w_in_byte  = i_data_byte;
            assign w_in_valid = 1'b1;
        end else begin : g_body
            assign w_in_byte  = w_byte[k-1];
            assign w_in_valid = w_valid[k-1];
        end

        mbps_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_ref         (w_ref),
            .i_shift_byte  (w_in_byte),
            .i_shift_valid (w_in_valid),
            .o_byte        (w_byte[k]),
            .o_valid       (w_valid[k]),
            .o_ok          (w_ok[k])
        );
    end

    // match decision for the incoming beat
    assign w_hit  = (w_len != '0) & ~r_found & (&w_ok);
    assign w_done = r_found | (w_hit & r_single);
    assign w_addr = w_hit ? (i_byte_address - ADDR_W'(w_len) + ADDR_W'(1)) : '0;

    // single-match latch, cleared by any write of single_mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cfg_we && i_cfg_index == CFG_SINGLE_MODE) begin
            r_found <= 1'b0;
        end else if (w_fire) begin
            r_found <= w_done;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_fire;
            end
        end else if (w_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload of both stages
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_found <= r_skid_found;
                r_out_addr  <= r_skid_addr;
                r_out_done  <= r_skid_done;
            end else begin
                r_out_found <= w_hit;
                r_out_addr  <= w_addr;
                r_out_done  <= w_done;
            end
        end else if (w_fire) begin
            r_skid_found <= w_hit;
            r_skid_addr  <= w_addr;
            r_skid_done  <= w_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_match_found   = r_out_found;
    assign o_match_address = r_out_addr;
    assign o_search_done   = r_out_done;

endmodule

`default_nettype wire

### src/mbps_checker.sv
// port-level checks of the masked byte pattern scanner, bound to the top level
`default_nettype none

module mbps_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              o_ready,
    input  wire                              o_valid,
    input  wire                              i_ready,
    input  wire                              o_match_found,
    input  wire [mbps_pkg::ADDR_W-1:0]       o_match_address,
    input  wire                              o_search_done
);
    import mbps_pkg::*;

    // a stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_found)
                                && $stable(o_match_address) && $stable(o_search_done))
        else $error("stalled result beat changed");

    // no match means a zero address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_match_found |-> o_match_address == '0)
        else $error("match address set without a match");

    // input only backs up when a result beat is waiting
    a_ready_backup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // reset empties the output and skid stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("beat left after reset");

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_mbps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_match_found   (o_match_found),
    .o_match_address (o_match_address),
    .o_search_done   (o_search_done)
);

`default_nettype wire

### tb/sv/tb_top.sv
// testbench of the masked byte pattern scanner: directed and random byte streams checked beat by beat
`timescale 1ns / 100ps

module tb_top;
    import mbps_pkg::*;

    localparam int STALL_MAX     = 13;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TOTAL_ITEMS   = 1150;
    localparam int PRINT_CAP     = 100;
    localparam int HOLD_CYCLES   = 120;

    typedef struct packed {
        logic              match_found;
        logic [ADDR_W-1:0] match_address;
        logic              search_done;
    } t_scan_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte    = '0;
    logic [ADDR_W-1:0]     i_byte_address = '0;
    logic                  i_region_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic                  o_match_found;
    logic [ADDR_W-1:0]     o_match_address;
    logic                  o_search_done;

    // mirror of the configuration registers, reset values
    logic [63:0]      mir_pat_lo   = '0;
    logic [63:0]      mir_pat_hi   = '0;
    logic [31:0]      mir_nib_mask = '0;
    logic [LEN_W-1:0] mir_len      = LEN_W'(1);
    logic             mir_single   = 1'b0;

    // mirror of the scan window state
    t_byte win [MAX_PATTERN] = '{default: '0};
    int    win_fill    = 0;
    logic  found_latch = 1'b0;

    t_scan_result awaited_results [$];

    int mismatches   = 0;
    int items_sent   = 0;
    int tx_max_gap   = STALL_MAX;
    int rx_max_stall = STALL_MAX;
    int rx_hold_req  = 0;
    int idle_cycles  = 0;

    masked_byte_pattern_scanner_core dut (.*);

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // pattern length in effect, saturated to the window depth
    function automatic int usable_len();
        return (int'(mir_len) > LIM) ? LIM : int'(mir_len);
    endfunction

    function automatic t_byte pat_at(input int i);
        logic [127:0] both;
        both = {mir_pat_hi, mir_pat_lo};
        return both[i*8 +: 8];
    endfunction

    // byte mask of the significant nibbles of pattern byte i
    function automatic t_byte care_at(input int i);
        return {{4{mir_nib_mask[2*i+1]}}, {4{mir_nib_mask[2*i]}}};
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // shift one byte into the mirrored window and queue the result it gives
    task automatic advance_window(input t_byte d, input logic [ADDR_W-1:0] a, input logic rs);
        int           len;
        int           k;
        logic         hit;
        t_scan_result r;
        len = usable_len();
        if (rs) begin
            for (k = 0; k < MAX_PATTERN; k++) win[k] = '0;
            win_fill = 0;
        end
        for (k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = d;
        if (win_fill < MAX_PATTERN) win_fill++;
        hit = (len > 0) && (win_fill >= len) && !found_latch;
        if (hit) begin
            for (k = 0; k < len; k++) begin
                if (((win[len-1-k] ^ pat_at(k)) & care_at(k)) != 8'h00) hit = 1'b0;
            end
        end
        if (hit && mir_single) found_latch = 1'b1;
        r.match_found   = hit;
        r.match_address = hit ? (a - 32'(len - 1)) : '0;
        r.search_done   = found_latch;
        awaited_results = {awaited_results, r};
    endtask

    // one register write, taken at the next edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:    mir_pat_lo   = val;
            CFG_PATTERN_HIGH:   mir_pat_hi   = val;
            CFG_NIBBLE_MASK:    mir_nib_mask = val[31:0];
            CFG_PATTERN_LENGTH: mir_len      = val[LEN_W-1:0];
            CFG_SINGLE_MODE: begin
                mir_single  = val[0];
                found_latch = 1'b0;
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one byte beat after a random gap and wait until it is taken
    task automatic send_byte(input t_byte d, input logic [ADDR_W-1:0] a, input logic rs);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= d;
        i_byte_address <= a;
        i_region_start <= rs;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        advance_window(d, a, rs);
        items_sent++;
    endtask

    // stop offering and wait for every awaited result
    task automatic drain_results();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // regions of random bytes with the pattern planted now and then
    task automatic scan_regions(input int n);
        int                left;
        int                rlen;
        int                k;
        int                pos;
        int                elen;
        logic [ADDR_W-1:0] a;
        t_byte             d;
        logic              rs;
        left = n;
        elen = usable_len();
        while (left > 0) begin
            rlen = $urandom_range(1, 40);
            if (rlen > left) rlen = left;
            case ($urandom_range(0, 7))
                0:       a = '0;
                1:       a = 32'hFFFF_FFFF - $urandom_range(0, 20);
                default: a = $urandom;
            endcase
            pos = -1;
            for (k = 0; k < rlen; k++) begin
                // occasional stray region start breaks a match in progress
                rs = (k == 0) || ($urandom_range(0, 49) == 0);
                if (pos < 0 && elen > 0 && $urandom_range(0, 5) == 0) pos = 0;
                if (pos >= 0) begin
                    d = (pat_at(pos) & care_at(pos)) | (8'($urandom) & ~care_at(pos));
                    pos++;
                    if (pos >= elen || $urandom_range(0, 29) == 0) pos = -1;
                end else if ($urandom_range(0, 3) == 0) begin
                    d = pat_at($urandom_range(0, 15));
                end else begin
                    d = 8'($urandom);
                end
                send_byte(d, a, rs);
                a = a + 1;
                if ($urandom_range(0, 99) == 0) a = $urandom;
            end
            left -= rlen;
        end
    endtask

    // reset values: length one, all wildcards, so every byte matches
    task automatic test_reset_defaults();
        send_byte(8'h00, 32'h0000_0000, 1'b1);
        send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_byte(8'hA5, 32'h8000_0000, 1'b1);
        send_byte(8'h5A, 32'h8000_0001, 1'b0);
        drain_results();
    endtask

    // full 16 byte pattern with wildcard nibbles, start address wrapping, match on region end
    task automatic test_full_length_wrap();
        int    k;
        t_byte p;
        t_byte m;
        write_reg(CFG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(CFG_NIBBLE_MASK, 64'h0000_0000_BFFF_F3FF);
        write_reg(CFG_PATTERN_LENGTH, 64'd16);
        for (k = 0; k < 16; k++) begin
            p = pat_at(k);
            m = care_at(k);
            // wildcard bits flipped against the pattern
            send_byte((p & m) | (~p & ~m), 32'hFFFF_FFF8 + k, k == 0);
        end
        drain_results();
    endtask

    // single mode stops after the first hit, a write to single_mode restarts it
    task automatic test_single_mode();
        write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0000_00AB);
        write_reg(CFG_NIBBLE_MASK, 64'h3);
        write_reg(CFG_PATTERN_LENGTH, 64'd1);
        write_reg(CFG_SINGLE_MODE, 64'd1);
        send_byte(8'hAB, 32'h0000_0100, 1'b1);
        send_byte(8'hAB, 32'h0000_0101, 1'b0);
        drain_results();
        write_reg(CFG_SINGLE_MODE, 64'd0);
        send_byte(8'hAB, 32'h0000_0102, 1'b0);
        drain_results();
    endtask

    // length zero never matches, oversize length saturates
    task automatic test_length_limits();
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        send_byte(8'hAB, 32'h0000_0103, 1'b0);
        drain_results();
        write_reg(CFG_PATTERN_LENGTH, 64'd31);
        send_byte(8'h00, 32'h0000_0104, 1'b0);
        drain_results();
    endtask

    // receiver holds off long while bytes keep coming, then the sender waits for all results
    task automatic test_backpressure();
        tx_max_gap   = 0;
        rx_max_stall = 0;
        write_reg(CFG_PATTERN_LENGTH, 64'd3);
        write_reg(CFG_NIBBLE_MASK, 64'hFFFF_FFFF);
        rx_hold_req = HOLD_CYCLES;
        scan_regions(48);
        drain_results();
        tx_max_gap   = STALL_MAX;
        rx_max_stall = STALL_MAX;
    endtask

    task automatic random_config();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] nm;
        int          len;
        case ($urandom_range(0, 5))
            0:       lo = '0;
            1:       lo = '1;
            default: lo = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0:       hi = '0;
            1:       hi = '1;
            default: hi = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 5))
            0:       nm = '0;
            1:       nm = '1;
            2:       nm = $urandom & $urandom;
            default: nm = $urandom | $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 1;
            2:       len = 16;
            3:       len = $urandom_range(17, 31);
            default: len = $urandom_range(1, 16);
        endcase
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_NIBBLE_MASK, {32'h0, nm});
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_SINGLE_MODE, 64'($urandom_range(0, 2) == 0));
    endtask

    // random phases, each with its own settings and idling
    task automatic test_random_regions();
        while (items_sent < TOTAL_ITEMS) begin
            random_config();
            case ($urandom_range(0, 3))
                0: begin
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                end
                1: begin
                    tx_max_gap   = STALL_MAX;
                    rx_max_stall = 0;
                end
                2: begin
                    tx_max_gap   = 0;
                    rx_max_stall = STALL_MAX;
                end
                default: begin
                    tx_max_gap   = STALL_MAX;
                    rx_max_stall = STALL_MAX;
                end
            endcase
            scan_regions($urandom_range(40, 90));
            drain_results();
        end
    endtask

    // result side: random stalls, each beat checked against the oldest awaited result
    initial begin : result_checker
        int           stall;
        t_scan_result got;
        t_scan_result want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.match_found   = o_match_found;
            got.match_address = o_match_address;
            got.search_done   = o_search_done;
            if (awaited_results.size() == 0) begin
                report_mismatch("beat with no result awaited", got.match_address, '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.match_found !== want.match_found)
                    report_mismatch("match_found", 32'(got.match_found), 32'(want.match_found));
                if (got.match_address !== want.match_address)
                    report_mismatch("match_address", got.match_address, want.match_address);
                if (got.search_done !== want.search_done)
                    report_mismatch("search_done", 32'(got.search_done), 32'(want.search_done));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_valid && o_ready) === 1'b1 || (o_valid && i_ready) === 1'b1) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_full_length_wrap();
        test_single_mode();
        test_length_limits();
        test_backpressure();
        test_random_regions();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
